/* rtl/hns_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package hns_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 11;
  localparam int LANES      = 3;
  localparam int MAG_W      = 25;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int ACC_W      = 84;
  localparam int STEP_W     = 4;
  localparam logic [STEP_W-1:0] STEP_FIRST = 4'd15;

  typedef enum logic [1:0] {
    CFG_MAP_WIDTH    = 2'd0,
    CFG_MAP_HEIGHT   = 2'd1,
    CFG_GRID_SPACING = 2'd2,
    CFG_HEIGHT_SCALE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [9:0]  column;
    logic [9:0]  row;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [15:0] normal_z;
    logic        frame_done;
  } normal_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic mul;
    logic sqr;
    logic init;
    logic step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit;
    logic last_step;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] top);
    logic [SIZE_W-1:0] r;
    if (v < SIZE_W'(3)) r = SIZE_W'(3);
    else if (v > top) r = top;
    else r = v;
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/hns_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module hns_ctrl import hns_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOAD = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_SQR  = 7'b0001000,
    ST_SUM  = 7'b0010000,
    ST_ITER = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d = sts_i.emit ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_SQR;
      end
      ST_SQR: begin
        cmd_o.sqr = 1'b1;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.init = 1'b1;
        state_d = ST_ITER;
      end
      ST_ITER: begin
        cmd_o.step = 1'b1;
        if (sts_i.last_step) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/hns_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module hns_datapath import hns_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire pixel_t      pix_i,
  input  wire ctrl_cmd_t   cmd_i,
  output ctrl_sts_t        sts_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output normal_t          nrm_o
);

  logic [SIZE_W-1:0] width_q, height_q;
  logic [15:0]       spacing_q, scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= SIZE_W'(1024);
      height_q  <= SIZE_W'(1024);
      spacing_q <= 16'd256;
      scale_q   <= 16'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAP_WIDTH:    width_q   <= cfg_data_i[SIZE_W-1:0];
        CFG_MAP_HEIGHT:   height_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_GRID_SPACING: spacing_q <= cfg_data_i;
        CFG_HEIGHT_SCALE: scale_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] w_eff, h_eff;
  assign w_eff = clamp_size(width_q, SIZE_W'(MAX_WIDTH));
  assign h_eff = clamp_size(height_q, SIZE_W'(MAX_HEIGHT));

  logic [7:0] upper_mem [MAX_WIDTH];
  logic [7:0] middle_mem [MAX_WIDTH];
  logic [7:0] rd_mid_q, rd_up_q, cur_q;
  logic [ADDR_W-1:0] col_q;
  logic [ROW_W-1:0]  row_q;
  logic [7:0] prev_q, back1_q, back2_q, top_q;
  logic [7:0] cur_d;

  always_comb begin
    cur_d = pix_i.red;
    if (pix_i.green > cur_d) cur_d = pix_i.green;
    if (pix_i.blue > cur_d) cur_d = pix_i.blue;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_mid_q <= middle_mem[col_q];
      rd_up_q  <= upper_mem[col_q];
      cur_q    <= cur_d;
    end
    if (cmd_i.load) begin
      upper_mem[col_q]  <= rd_mid_q;
      middle_mem[col_q] <= cur_q;
    end
  end

  logic col_last, row_last;
  assign col_last = ({1'b0, col_q} + SIZE_W'(1)) >= w_eff;
  assign row_last = ({1'b0, row_q} + SIZE_W'(1)) >= h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      prev_q  <= '0;
      back1_q <= '0;
      back2_q <= '0;
      top_q   <= '0;
    end else if (cmd_i.load) begin
      prev_q  <= cur_q;
      back2_q <= back1_q;
      back1_q <= rd_mid_q;
      top_q   <= rd_up_q;
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + ADDR_W'(1);
      end
    end
  end

  logic [7:0] dl_q, dt_q;
  logic [9:0] ocol_q, orow_q;
  logic       ofd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dl_q   <= (back2_q > rd_mid_q) ? back2_q - rd_mid_q : rd_mid_q - back2_q;
      dt_q   <= (top_q > prev_q) ? top_q - prev_q : prev_q - top_q;
      ocol_q <= 10'(col_q - ADDR_W'(1));
      orow_q <= 10'(row_q - ROW_W'(1));
      ofd_q  <= col_last && row_last;
    end
  end

  logic [MAG_W-1:0] mag_q [LANES];
  logic [SQ_W-1:0]  sq_q [LANES];
  logic [ACC_W-1:0] p_q [LANES];
  logic [ACC_W-1:0] a_q [LANES];
  logic [15:0]      qv_q [LANES];
  logic [ACC_W-1:0] b_q;
  logic [STEP_W-1:0] k_q;
  logic [SQ_W:0] sum_c;

  assign sum_c = {1'b0, sq_q[0]} + {1'b0, sq_q[1]} + {1'b0, sq_q[2]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      mag_q[0] <= MAG_W'(scale_q) * MAG_W'(dl_q);
      mag_q[1] <= MAG_W'(10'd510) * MAG_W'(spacing_q);
      mag_q[2] <= MAG_W'(scale_q) * MAG_W'(dt_q);
    end
    if (cmd_i.init) begin
      b_q <= ACC_W'({sum_c, 30'b0});
      k_q <= STEP_FIRST;
    end else if (cmd_i.step) begin
      b_q <= b_q >> 2;
      k_q <= k_q - STEP_W'(1);
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [ACC_W-1:0] trial;
    logic             fits;
    assign trial = p_q[i] + a_q[i] + b_q;
    assign fits  = trial <= ACC_W'({sq_q[i], 30'b0});
    always_ff @(posedge clk_i) begin
      if (cmd_i.sqr) begin
        sq_q[i] <= SQ_W'(mag_q[i]) * SQ_W'(mag_q[i]);
      end
      if (cmd_i.init) begin
        p_q[i]  <= '0;
        a_q[i]  <= '0;
        qv_q[i] <= '0;
      end else if (cmd_i.step) begin
        if (fits) begin
          p_q[i]  <= trial;
          a_q[i]  <= (a_q[i] >> 1) + b_q;
          qv_q[i] <= qv_q[i] | (16'd1 << k_q);
        end else begin
          a_q[i] <= a_q[i] >> 1;
        end
      end
    end
  end

  logic out_valid_q;
  normal_t nrm_q;
  logic zero_n;
  assign zero_n = (spacing_q == 16'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      nrm_q.column     <= ocol_q;
      nrm_q.row        <= orow_q;
      nrm_q.normal_x   <= zero_n ? 16'd0 : qv_q[0];
      nrm_q.normal_y   <= zero_n ? 16'd0 : qv_q[1];
      nrm_q.normal_z   <= zero_n ? 16'd0 : qv_q[2];
      nrm_q.frame_done <= ofd_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign nrm_o           = nrm_q;
  assign sts_o.emit      = (col_q >= ADDR_W'(2)) && (row_q >= ROW_W'(2));
  assign sts_o.last_step = (k_q == '0);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule
`default_nettype wire

/* rtl/heightmap_normal_stream.sv */
// Each transaction is captured, then loaded; an interior one goes on through multiply, square,
// sum, iterate and done states, a border one returns to idle. Input stays stalled until the
// transaction is finished, and the done state waits while the previous normal is held by out_stall_i.
// Normalization is a 16-step shared bit-serial one, three lanes in parallel.
// Reset clears control, counters, window and configuration (1024, 1024, 256, 256);
// line stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module heightmap_normal_stream import hns_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire pixel_t      pix_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output normal_t          nrm_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  hns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hns_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (pix_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .nrm_o       (nrm_o)
  );

endmodule
`default_nettype wire

/* rtl/hns_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module hns_checker import hns_pkg::*; (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    in_valid_i,
  input wire logic    in_stall_o,
  input wire logic    out_valid_o,
  input wire logic    out_stall_i,
  input wire normal_t nrm_o
);

  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("transaction accepted without stall on the following cycle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(nrm_o))
    else $error("stalled output transaction changed");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> nrm_o.normal_x <= 16'd32768 && nrm_o.normal_y <= 16'd32768
                    && nrm_o.normal_z <= 16'd32768)
    else $error("normal component above one");

  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> nrm_o.column != 10'd0 && nrm_o.row != 10'd0)
    else $error("normal reported for a border pixel");

endmodule

bind heightmap_normal_stream hns_checker u_hns_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .nrm_o       (nrm_o)
);
`default_nettype wire
